/* hdl/vna_pkg.sv */
// ----------------------------------------------------------------------------
// vna_pkg
// Shared types and constants of the vertex normal accumulator: widths, item
// codes and the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package vna_pkg;

  localparam int IDX_W      = 10;
  localparam int VERTICES   = 1024;
  localparam int COORD_W    = 16;
  localparam int EDGE_W     = COORD_W + 1;
  localparam int VEC_W      = 36;
  localparam int ACC_W      = 24;
  localparam int NORM_W     = 16;
  localparam int MUL_W      = 31;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int SQ_W       = 63;
  localparam int ROOT_W     = 31;
  localparam int UNIT_SHIFT = 14;
  localparam int QUO_W      = UNIT_SHIFT + 1;
  localparam int DIV_W      = ROOT_W + QUO_W;
  localparam int NORM_TOP   = 30;
  localparam int STEP_W     = 3;

  typedef logic [1:0] func_t;
  localparam func_t FUNC_LOAD  = 2'd0;
  localparam func_t FUNC_TRI   = 2'd1;
  localparam func_t FUNC_QUERY = 2'd2;
  localparam func_t FUNC_NOP   = 2'd3;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLEAR,
    OP_CAPTURE,
    OP_LOAD,
    OP_POS_RD,
    OP_EDGE,
    OP_CROSS,
    OP_ACC_RD,
    OP_ACC_GET,
    OP_MAG,
    OP_SHR,
    OP_SHL,
    OP_SQUARE,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_DIV_STORE,
    OP_ACC_WR,
    OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t              op;
    logic [STEP_W-1:0]   step;
  } dp_cmd_t;

  typedef struct packed {
    logic mag_zero;
    logic mag_over;
    logic mag_low;
    logic clr_last;
  } dp_stat_t;

endpackage

/* hdl/vna_datapath.sv */
// ----------------------------------------------------------------------------
// vna_datapath
// Position and accumulator memories, shared multiplier, normalizer, bitwise
// square root, restoring divider and result registers.
// ----------------------------------------------------------------------------
module vna_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  vna_pkg::dp_cmd_t              cmd,
  output vna_pkg::dp_stat_t             stat,
  input  logic [vna_pkg::IDX_W-1:0]     vertex_index,
  input  logic [vna_pkg::COORD_W-1:0]   pos_x,
  input  logic [vna_pkg::COORD_W-1:0]   pos_y,
  input  logic [vna_pkg::COORD_W-1:0]   pos_z,
  input  logic [vna_pkg::IDX_W-1:0]     corner_a,
  input  logic [vna_pkg::IDX_W-1:0]     corner_b,
  input  logic [vna_pkg::IDX_W-1:0]     corner_c,
  output logic                          done,
  output logic signed [vna_pkg::NORM_W-1:0] normal_x,
  output logic signed [vna_pkg::NORM_W-1:0] normal_y,
  output logic signed [vna_pkg::NORM_W-1:0] normal_z,
  output logic                          zero_normal
);
  import vna_pkg::*;

  logic [3*COORD_W-1:0] pos_mem [VERTICES];
  logic [3*ACC_W-1:0]   acc_mem [VERTICES];

  logic [IDX_W-1:0]          vidx;
  logic [IDX_W-1:0]          corner [3];
  logic [3*COORD_W-1:0]      pos_in;
  logic [3*COORD_W-1:0]      pos_q;
  logic [3*ACC_W-1:0]        acc_q;
  logic signed [COORD_W-1:0] pt [3][3];
  logic signed [EDGE_W-1:0]  e1 [3];
  logic signed [EDGE_W-1:0]  e2 [3];
  logic signed [VEC_W-1:0]   vec [3];
  logic [VEC_W-1:0]          mag [3];
  logic                      neg [3];
  logic signed [PROD_W-1:0]  mul_p;
  logic signed [MUL_W-1:0]   mul_a;
  logic signed [MUL_W-1:0]   mul_b;
  logic [PROD_W-1:0]         sum;
  logic [SQ_W-1:0]           sq_n;
  logic [SQ_W-1:0]           sq_res;
  logic [SQ_W-1:0]           sq_bit;
  logic [SQ_W-1:0]           sq_trial;
  logic [ROOT_W-1:0]         root;
  logic [DIV_W-1:0]          rem;
  logic [DIV_W-2:0]          dvs;
  logic [QUO_W-1:0]          quo;
  logic signed [NORM_W-1:0]  nrm [3];
  logic [IDX_W-1:0]          clr_addr;
  logic [VEC_W-1:0]          or_m;
  logic [1:0]                sel;
  logic [2:0]                cross_j;

  logic                      pos_we;
  logic [IDX_W-1:0]          pos_ra;
  logic                      acc_we;
  logic [IDX_W-1:0]          acc_wa;
  logic [IDX_W-1:0]          acc_ra;
  logic [3*ACC_W-1:0]        acc_wd;

  function automatic logic signed [ACC_W-1:0] sat_add(
    input logic signed [ACC_W-1:0]  a,
    input logic signed [NORM_W-1:0] b
  );
    logic signed [ACC_W:0] s;
    s = {a[ACC_W-1], a} + {{(ACC_W+1-NORM_W){b[NORM_W-1]}}, b};
    if (s[ACC_W] != s[ACC_W-1]) begin
      return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end
    return s[ACC_W-1:0];
  endfunction

  function automatic logic signed [MUL_W-1:0] ext_edge(input logic signed [EDGE_W-1:0] e);
    return {{(MUL_W-EDGE_W){e[EDGE_W-1]}}, e};
  endfunction

  assign sel      = cmd.step[1:0];
  assign cross_j  = cmd.step - 3'd1;
  assign or_m     = mag[0] | mag[1] | mag[2];
  assign root     = sq_res[ROOT_W-1:0];
  assign sq_trial = sq_res + sq_bit;

  assign stat.mag_zero = (or_m == '0);
  assign stat.mag_over = |or_m[VEC_W-1:NORM_TOP];
  assign stat.mag_low  = !or_m[NORM_TOP-1];
  assign stat.clr_last = (clr_addr == {IDX_W{1'b1}});

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (cmd.op == OP_CROSS) begin
      case (cmd.step)
        3'd0: begin mul_a = ext_edge(e1[1]); mul_b = ext_edge(e2[2]); end
        3'd1: begin mul_a = ext_edge(e1[2]); mul_b = ext_edge(e2[1]); end
        3'd2: begin mul_a = ext_edge(e1[2]); mul_b = ext_edge(e2[0]); end
        3'd3: begin mul_a = ext_edge(e1[0]); mul_b = ext_edge(e2[2]); end
        3'd4: begin mul_a = ext_edge(e1[0]); mul_b = ext_edge(e2[1]); end
        3'd5: begin mul_a = ext_edge(e1[1]); mul_b = ext_edge(e2[0]); end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end else if (cmd.op == OP_SQUARE && cmd.step < 3'd3) begin
      mul_a = {1'b0, mag[sel][NORM_TOP-1:0]};
      mul_b = {1'b0, mag[sel][NORM_TOP-1:0]};
    end
  end

  // memory port controls
  always_comb begin
    pos_we = (cmd.op == OP_LOAD);
    pos_ra = (sel == 2'd0) ? corner[0] : (sel == 2'd1) ? corner[1] : corner[2];
    acc_ra = (cmd.step == 3'd3) ? vidx : pos_ra;
    acc_we = 1'b0;
    acc_wa = vidx;
    acc_wd = '0;
    case (cmd.op)
      OP_CLEAR: begin
        acc_we = 1'b1;
        acc_wa = clr_addr;
      end
      OP_LOAD: begin
        acc_we = 1'b1;
      end
      OP_ACC_WR: begin
        acc_we = 1'b1;
        acc_wa = pos_ra;
        acc_wd = {sat_add(acc_q[3*ACC_W-1 -: ACC_W], nrm[0]),
                  sat_add(acc_q[2*ACC_W-1 -: ACC_W], nrm[1]),
                  sat_add(acc_q[ACC_W-1:0], nrm[2])};
      end
      default: begin
        acc_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[vidx] <= pos_in;
    end
    pos_q <= pos_mem[pos_ra];
  end

  always_ff @(posedge clk) begin
    if (acc_we) begin
      acc_mem[acc_wa] <= acc_wd;
    end
    acc_q <= acc_mem[acc_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      done     <= 1'b0;
    end else begin
      done <= (cmd.op == OP_OUT);
      if (cmd.op == OP_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
    case (cmd.op)
      OP_CAPTURE: begin
        vidx      <= vertex_index;
        pos_in    <= {pos_x, pos_y, pos_z};
        corner[0] <= corner_a;
        corner[1] <= corner_b;
        corner[2] <= corner_c;
      end
      OP_POS_RD: begin
        if (cmd.step != 3'd0) begin
          pt[cross_j[1:0]][0] <= pos_q[3*COORD_W-1 -: COORD_W];
          pt[cross_j[1:0]][1] <= pos_q[2*COORD_W-1 -: COORD_W];
          pt[cross_j[1:0]][2] <= pos_q[COORD_W-1:0];
        end
      end
      OP_EDGE: begin
        for (int k = 0; k < 3; k++) begin
          e1[k] <= {pt[1][k][COORD_W-1], pt[1][k]} - {pt[0][k][COORD_W-1], pt[0][k]};
          e2[k] <= {pt[2][k][COORD_W-1], pt[2][k]} - {pt[0][k][COORD_W-1], pt[0][k]};
        end
      end
      OP_CROSS: begin
        if (cmd.step != 3'd0) begin
          if (!cross_j[0]) begin
            vec[cross_j[2:1]] <= mul_p[VEC_W-1:0];
          end else begin
            vec[cross_j[2:1]] <= vec[cross_j[2:1]] - mul_p[VEC_W-1:0];
          end
        end
      end
      OP_ACC_GET: begin
        vec[0] <= {{(VEC_W-ACC_W){acc_q[3*ACC_W-1]}}, acc_q[3*ACC_W-1 -: ACC_W]};
        vec[1] <= {{(VEC_W-ACC_W){acc_q[2*ACC_W-1]}}, acc_q[2*ACC_W-1 -: ACC_W]};
        vec[2] <= {{(VEC_W-ACC_W){acc_q[ACC_W-1]}}, acc_q[ACC_W-1:0]};
      end
      OP_MAG: begin
        for (int k = 0; k < 3; k++) begin
          neg[k] <= vec[k][VEC_W-1];
          mag[k] <= vec[k][VEC_W-1] ? (~vec[k] + 1'b1) : vec[k];
        end
      end
      OP_SHR: begin
        for (int k = 0; k < 3; k++) begin
          mag[k] <= mag[k] >> 1;
        end
      end
      OP_SHL: begin
        for (int k = 0; k < 3; k++) begin
          mag[k] <= mag[k] << 1;
        end
      end
      OP_SQUARE: begin
        if (cmd.step == 3'd1) begin
          sum <= mul_p;
        end else if (cmd.step != 3'd0) begin
          sum <= sum + mul_p;
        end
      end
      OP_SQRT_INIT: begin
        sq_n   <= {1'b0, sum};
        sq_res <= '0;
        sq_bit <= {1'b1, {(SQ_W-1){1'b0}}};
      end
      OP_SQRT_STEP: begin
        if (sq_n >= sq_trial) begin
          sq_n   <= sq_n - sq_trial;
          sq_res <= (sq_res >> 1) + sq_bit;
        end else begin
          sq_res <= sq_res >> 1;
        end
        sq_bit <= sq_bit >> 2;
      end
      OP_DIV_INIT: begin
        rem <= {2'b00, mag[sel][NORM_TOP-1:0], {UNIT_SHIFT{1'b0}}}
               + {{QUO_W{1'b0}}, root >> 1};
        dvs <= {root, {UNIT_SHIFT{1'b0}}};
        quo <= '0;
      end
      OP_DIV_STEP: begin
        if (rem >= {1'b0, dvs}) begin
          rem <= rem - {1'b0, dvs};
          quo <= {quo[QUO_W-2:0], 1'b1};
        end else begin
          quo <= {quo[QUO_W-2:0], 1'b0};
        end
        dvs <= dvs >> 1;
      end
      OP_DIV_STORE: begin
        nrm[sel] <= neg[sel] ? (NORM_W'(0) - {1'b0, quo}) : {1'b0, quo};
      end
      OP_OUT: begin
        zero_normal <= stat.mag_zero;
        normal_x    <= stat.mag_zero ? '0 : nrm[0];
        normal_y    <= stat.mag_zero ? '0 : nrm[1];
        normal_z    <= stat.mag_zero ? '0 : nrm[2];
      end
      default: begin
      end
    endcase
  end

  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held for two cycles");
  a_zero_out: assert property (@(posedge clk) disable iff (rst)
    (done && zero_normal) |-> (normal_x == 0 && normal_y == 0 && normal_z == 0))
    else $error("zero flag with nonzero normal");
  a_div_range: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_DIV_STEP) |-> (rem < {dvs, 1'b0}))
    else $error("divider remainder out of range");

endmodule

/* hdl/vna_controller.sv */
// ----------------------------------------------------------------------------
// vna_controller
// Sequencer for load, triangle and query requests; steps the datapath one
// operation per cycle and runs the accumulator clearing pass after reset.
// ----------------------------------------------------------------------------
module vna_controller (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  vna_pkg::func_t     func,
  output logic               busy,
  output vna_pkg::dp_cmd_t   cmd,
  input  vna_pkg::dp_stat_t  stat
);
  import vna_pkg::*;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_LOAD, S_POS, S_EDGE, S_CROSS, S_QRD, S_QGET, S_MAG,
    S_NORM, S_SQ, S_SQI, S_SQRT, S_DIVI, S_DIV, S_DIVS, S_ACRD, S_ACWR, S_OUT
  } state_t;

  state_t     state;
  logic [4:0] cnt;
  logic [1:0] k;
  logic       is_query;

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR;
      cnt      <= '0;
      k        <= '0;
      is_query <= 1'b0;
    end else begin
      unique case (state)
        S_CLR: begin
          if (stat.clr_last) state <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            is_query <= (func == FUNC_QUERY);
            cnt      <= '0;
            k        <= '0;
            unique case (func)
              FUNC_LOAD:  state <= S_LOAD;
              FUNC_TRI:   state <= S_POS;
              FUNC_QUERY: state <= S_QRD;
              default:    state <= S_IDLE;
            endcase
          end
        end
        S_LOAD: state <= S_IDLE;
        S_POS: begin
          cnt <= cnt + 1'b1;
          if (cnt == 5'd3) begin
            cnt   <= '0;
            state <= S_EDGE;
          end
        end
        S_EDGE: state <= S_CROSS;
        S_CROSS: begin
          cnt <= cnt + 1'b1;
          if (cnt == 5'd6) begin
            cnt   <= '0;
            state <= S_MAG;
          end
        end
        S_QRD:  state <= S_QGET;
        S_QGET: state <= S_MAG;
        S_MAG:  state <= S_NORM;
        S_NORM: begin
          if (stat.mag_zero) begin
            state <= is_query ? S_OUT : S_IDLE;
          end else if (!stat.mag_over && !stat.mag_low) begin
            cnt   <= '0;
            state <= S_SQ;
          end
        end
        S_SQ: begin
          cnt <= cnt + 1'b1;
          if (cnt == 5'd3) begin
            cnt   <= '0;
            state <= S_SQI;
          end
        end
        S_SQI: state <= S_SQRT;
        S_SQRT: begin
          cnt <= cnt + 1'b1;
          if (cnt == 5'd31) begin
            cnt   <= '0;
            k     <= '0;
            state <= S_DIVI;
          end
        end
        S_DIVI: begin
          cnt   <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == 5'd14) state <= S_DIVS;
        end
        S_DIVS: begin
          if (k == 2'd2) begin
            k     <= '0;
            state <= is_query ? S_OUT : S_ACRD;
          end else begin
            k     <= k + 1'b1;
            state <= S_DIVI;
          end
        end
        S_ACRD: state <= S_ACWR;
        S_ACWR: begin
          if (k == 2'd2) begin
            state <= S_IDLE;
          end else begin
            k     <= k + 1'b1;
            state <= S_ACRD;
          end
        end
        S_OUT: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd.op   = OP_NONE;
    cmd.step = '0;
    unique case (state)
      S_CLR:   cmd.op = OP_CLEAR;
      S_IDLE:  cmd.op = start ? OP_CAPTURE : OP_NONE;
      S_LOAD:  cmd.op = OP_LOAD;
      S_POS:   begin cmd.op = OP_POS_RD; cmd.step = cnt[STEP_W-1:0]; end
      S_EDGE:  cmd.op = OP_EDGE;
      S_CROSS: begin cmd.op = OP_CROSS; cmd.step = cnt[STEP_W-1:0]; end
      S_QRD:   begin cmd.op = OP_ACC_RD; cmd.step = 3'd3; end
      S_QGET:  cmd.op = OP_ACC_GET;
      S_MAG:   cmd.op = OP_MAG;
      S_NORM: begin
        if (stat.mag_zero)      cmd.op = OP_NONE;
        else if (stat.mag_over) cmd.op = OP_SHR;
        else if (stat.mag_low)  cmd.op = OP_SHL;
        else                    cmd.op = OP_NONE;
      end
      S_SQ:    begin cmd.op = OP_SQUARE; cmd.step = cnt[STEP_W-1:0]; end
      S_SQI:   cmd.op = OP_SQRT_INIT;
      S_SQRT:  cmd.op = OP_SQRT_STEP;
      S_DIVI:  begin cmd.op = OP_DIV_INIT; cmd.step = {1'b0, k}; end
      S_DIV:   cmd.op = OP_DIV_STEP;
      S_DIVS:  begin cmd.op = OP_DIV_STORE; cmd.step = {1'b0, k}; end
      S_ACRD:  begin cmd.op = OP_ACC_RD; cmd.step = {1'b0, k}; end
      S_ACWR:  begin cmd.op = OP_ACC_WR; cmd.step = {1'b0, k}; end
      S_OUT:   cmd.op = OP_OUT;
      default: cmd.op = OP_NONE;
    endcase
  end

  a_out_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |=> (state == S_IDLE))
    else $error("result state not followed by idle");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && func != FUNC_NOP) |=> busy)
    else $error("request accepted without going busy");
  a_corner_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_ACRD || state == S_ACWR || state == S_DIVI) |-> (k != 2'd3))
    else $error("component index out of range");

endmodule

/* hdl/vertex_normal_accumulator_unit.sv */
// ----------------------------------------------------------------------------
// vertex_normal_accumulator_unit
// Vertex position store with per-vertex face normal accumulators; triangles
// add their unit normal to each corner, queries return the unit average.
// ----------------------------------------------------------------------------
//  channel   handshake          payload
//  request   start / busy       func, vertex_index, pos_x/y/z, corner_a/b/c
//  result    done (one cycle)   normal_x/y/z, zero_normal
//
//  query and triangle time is set by the one-bit-per-cycle normalizer,
//  32-step square root and 15-step divider, which a zero accumulator
//  or a degenerate triangle skips.
//  after reset the accumulator memory is cleared, all 1024 entries, with busy high.
//  results cannot be stalled; done marks each one for exactly one cycle.
// ----------------------------------------------------------------------------
module vertex_normal_accumulator_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    func,
  input  logic [vna_pkg::IDX_W-1:0]     vertex_index,
  input  logic signed [vna_pkg::COORD_W-1:0] pos_x,
  input  logic signed [vna_pkg::COORD_W-1:0] pos_y,
  input  logic signed [vna_pkg::COORD_W-1:0] pos_z,
  input  logic [vna_pkg::IDX_W-1:0]     corner_a,
  input  logic [vna_pkg::IDX_W-1:0]     corner_b,
  input  logic [vna_pkg::IDX_W-1:0]     corner_c,
  output logic                          done,
  output logic signed [vna_pkg::NORM_W-1:0] normal_x,
  output logic signed [vna_pkg::NORM_W-1:0] normal_y,
  output logic signed [vna_pkg::NORM_W-1:0] normal_z,
  output logic                          zero_normal
);
  import vna_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  vna_controller u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .func  (func_t'(func)),
    .busy  (busy),
    .cmd   (cmd),
    .stat  (stat)
  );

  vna_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .vertex_index (vertex_index),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .pos_z        (pos_z),
    .corner_a     (corner_a),
    .corner_b     (corner_b),
    .corner_c     (corner_c),
    .done         (done),
    .normal_x     (normal_x),
    .normal_y     (normal_y),
    .normal_z     (normal_z),
    .zero_normal  (zero_normal)
  );

endmodule
